// ----- sv/lpi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpi_pkg
// Shared types and constants of the line and plane intersection block.
// ----------------------------------------------------------------------------
package lpi_pkg;

   localparam int QuoWidth = 51;   // |num| * 2^16 < 2^51
   localparam int DvsWidth = 34;   // |den| < 2^34
   localparam int RemWidth = 35;

   localparam logic [46:0] T_LIMIT = 47'h4000_0000_0000;

   localparam logic [2:0] CSR_PLANE_A      = 3'd0;
   localparam logic [2:0] CSR_PLANE_B      = 3'd1;
   localparam logic [2:0] CSR_PLANE_C      = 3'd2;
   localparam logic [2:0] CSR_PLANE_OFFSET = 3'd3;

   typedef struct packed {
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [15:0] first_z;
      logic signed [15:0] second_x;
      logic signed [15:0] second_y;
      logic signed [15:0] second_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic signed [31:0] hit_z;
      logic               parallel;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
      logic signed [31:0] d;
   } plane_type;

   typedef struct packed {
      logic [RemWidth-1:0] rem;
      logic [QuoWidth-1:0] quo;
      logic [DvsWidth-1:0] dvs;
      logic                neg;
      logic                par;
      logic signed [15:0]  x1;
      logic signed [15:0]  y1;
      logic signed [15:0]  z1;
      logic signed [16:0]  dx;
      logic signed [16:0]  dy;
      logic signed [16:0]  dz;
   } div_type;

endpackage

// ----- sv/lpi_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpi_front
// Forms numerator and denominator magnitudes over two stages.
// ----------------------------------------------------------------------------
module lpi_front
   import lpi_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  req_type   in_data,
   input  plane_type plane,
   output logic      out_valid,
   output div_type   out_data
);

   logic               v1_ff, v1_in, v2_ff, v2_in;
   logic signed [31:0] pa_ff, pb_ff, pc_ff, pa_in, pb_in, pc_in;
   logic signed [32:0] qa_ff, qb_ff, qc_ff, qa_in, qb_in, qc_in;
   logic signed [31:0] d_ff;
   logic signed [15:0] x1_ff, y1_ff, z1_ff;
   logic signed [16:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic signed [34:0] num, den;
   logic [34:0]        num_abs, den_abs;
   div_type            out_ff, out_in;

   always_comb begin
      dx_in = 17'(in_data.second_x) - 17'(in_data.first_x);
      dy_in = 17'(in_data.second_y) - 17'(in_data.first_y);
      dz_in = 17'(in_data.second_z) - 17'(in_data.first_z);
      pa_in = plane.a * in_data.first_x;
      pb_in = plane.b * in_data.first_y;
      pc_in = plane.c * in_data.first_z;
      qa_in = 33'(plane.a) * dx_in;
      qb_in = 33'(plane.b) * dy_in;
      qc_in = 33'(plane.c) * dz_in;
      v1_in = in_valid;
   end

   always_comb begin
      num = 35'(pa_ff) + 35'(pb_ff) + 35'(pc_ff) + 35'(d_ff);
      den = 35'(qa_ff) + 35'(qb_ff) + 35'(qc_ff);
      num_abs = num[34] ? 35'(-num) : 35'(num);
      den_abs = den[34] ? 35'(-den) : 35'(den);
      out_in.rem = '0;
      out_in.quo = {num_abs[QuoWidth-17:0], 16'h0000};
      out_in.dvs = den_abs[DvsWidth-1:0];
      // t = -num/den is negative when num and den share a sign
      out_in.neg = ~(num[34] ^ den[34]);
      out_in.par = (den == '0);
      out_in.x1  = x1_ff;
      out_in.y1  = y1_ff;
      out_in.z1  = z1_ff;
      out_in.dx  = dx_ff;
      out_in.dy  = dy_ff;
      out_in.dz  = dz_ff;
      v2_in = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         pc_ff  <= pc_in;
         qa_ff  <= qa_in;
         qb_ff  <= qb_in;
         qc_ff  <= qc_in;
         d_ff   <= plane.d;
         x1_ff  <= in_data.first_x;
         y1_ff  <= in_data.first_y;
         z1_ff  <= in_data.first_z;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         dz_ff  <= dz_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = out_ff;

endmodule

// ----- sv/lpi_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpi_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module lpi_div_cell
   import lpi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  div_type in_data,
   output logic    out_valid,
   output div_type out_data
);

   logic                valid_ff;
   div_type             data_ff, data_in;
   logic [RemWidth-1:0] rem_sh;
   logic [RemWidth:0]   diff;
   logic                ge;

   always_comb begin
      rem_sh  = {in_data.rem[RemWidth-2:0], in_data.quo[QuoWidth-1]};
      diff    = {1'b0, rem_sh} - (RemWidth+1)'(in_data.dvs);
      ge      = ~diff[RemWidth];
      data_in = in_data;
      data_in.rem = ge ? diff[RemWidth-1:0] : rem_sh;
      data_in.quo = {in_data.quo[QuoWidth-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- sv/lpi_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpi_back
// Applies the parameter t to the line and saturates the point.
// ----------------------------------------------------------------------------
module lpi_back
   import lpi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  div_type in_data,
   output logic    out_valid,
   output rsp_type out_data
);

   logic               v1_ff, v2_ff;
   logic [46:0]        t_mag;
   logic signed [47:0] t;
   logic signed [64:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [15:0] x1_ff, y1_ff, z1_ff;
   logic               par_ff;
   logic               sx, sy, sz;
   logic signed [31:0] hx, hy, hz;
   rsp_type            rsp_ff, rsp_in;

   function automatic logic signed [31:0] clamp32(
      input logic signed [15:0] p,
      input logic signed [64:0] prod,
      output logic              sat
   );
      logic signed [65:0] r;
      begin
         r = (66'(p) <<< 8) + 66'(prod >>> 8);
         sat = 1'b1;
         if (r > 66'sh7FFF_FFFF) begin
            clamp32 = 32'sh7FFF_FFFF;
         end else if (r < -66'sh8000_0000) begin
            clamp32 = -32'sh8000_0000;
         end else begin
            clamp32 = r[31:0];
            sat = 1'b0;
         end
      end
   endfunction

   always_comb begin
      t_mag = (in_data.quo > QuoWidth'(T_LIMIT)) ? T_LIMIT : in_data.quo[46:0];
      t     = in_data.neg ? -signed'({1'b0, t_mag}) : signed'({1'b0, t_mag});
      px_in = 65'(t) * 65'(in_data.dx);
      py_in = 65'(t) * 65'(in_data.dy);
      pz_in = 65'(t) * 65'(in_data.dz);
   end

   always_comb begin
      hx = clamp32(x1_ff, px_ff, sx);
      hy = clamp32(y1_ff, py_ff, sy);
      hz = clamp32(z1_ff, pz_ff, sz);
      if (par_ff) begin
         rsp_in = '{hit_x: '0, hit_y: '0, hit_z: '0, parallel: 1'b1, saturated: 1'b0};
      end else begin
         rsp_in = '{hit_x: hx, hit_y: hy, hit_z: hz, parallel: 1'b0,
                    saturated: sx | sy | sz};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         pz_ff  <= pz_in;
         x1_ff  <= in_data.x1;
         y1_ff  <= in_data.y1;
         z1_ff  <= in_data.z1;
         par_ff <= in_data.par;
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = rsp_ff;

endmodule

// ----- sv/line_plane_intersection_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_plane_intersection_top
// Intersects the line through two points with a configured plane.
// ----------------------------------------------------------------------------
// The plane a, b, c (Q8.8) and d (Q16.16) are written through the csr_ port;
// csr_ready is always high and indexes beyond the plane offset are ignored.
// Each req_ word carries two Q8.8 points; each rsp_ word carries the Q16.16
// intersection with parallel and saturated flags, one word per request.
// The front stages form numerator and denominator, a row of
// 51 division cells yields one quotient bit each, and the back stages
// multiply and saturate, the last being the output register.
// Throughput is one word per cycle. The whole pipeline advances together;
// when rsp_stall holds a valid output, req_stall is raised and every stage
// holds. Reset (synchronous) empties the pipeline and clears the plane.
// ----------------------------------------------------------------------------
module line_plane_intersection_top
   import lpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   plane_type plane_ff, plane_in;
   logic      en;
   logic      cv [0:QuoWidth];
   div_type   cd [0:QuoWidth];

   always_comb begin
      plane_in = plane_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PLANE_A:      plane_in.a = csr_data[15:0];
            CSR_PLANE_B:      plane_in.b = csr_data[15:0];
            CSR_PLANE_C:      plane_in.c = csr_data[15:0];
            CSR_PLANE_OFFSET: plane_in.d = csr_data;
            default:          plane_in = plane_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else begin
         plane_ff <= plane_in;
      end
   end

   assign csr_ready = 1'b1;
   assign en        = ~(rsp_valid & rsp_stall);
   assign req_stall = ~en;

   lpi_front u_front (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid), .in_data(req_data), .plane(plane_ff),
      .out_valid(cv[0]), .out_data(cd[0])
   );

   for (genvar i = 0; i < QuoWidth; i++) begin : g_cell
      lpi_div_cell u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(cv[i]), .in_data(cd[i]),
         .out_valid(cv[i+1]), .out_data(cd[i+1])
      );
   end

   lpi_back u_back (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(cv[QuoWidth]), .in_data(cd[QuoWidth]),
      .out_valid(rsp_valid), .out_data(rsp_data)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.parallel |->
         rsp_data.hit_x == 0 && rsp_data.hit_y == 0 && rsp_data.hit_z == 0
         && !rsp_data.saturated)
      else $error("parallel word carries a point");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.hit_x == 32'sh7FFF_FFFF || rsp_data.hit_x == -32'sh8000_0000
         || rsp_data.hit_y == 32'sh7FFF_FFFF || rsp_data.hit_y == -32'sh8000_0000
         || rsp_data.hit_z == 32'sh7FFF_FFFF || rsp_data.hit_z == -32'sh8000_0000)
      else $error("saturated flag without a clamped coordinate");

endmodule

// ----- tb/sv/tb_line_plane_intersection_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_plane_intersection_top
// Streams point pairs through the intersection block and checks each result.
// ----------------------------------------------------------------------------
// The plane is set through the csr_ port while the pipeline is empty. Every
// accepted request is predicted in full-width integer arithmetic and the
// expected word is queued; rsp_ words are compared field by field in order.
// Idle and stall bursts fall on both sides, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_line_plane_intersection_top;
   import lpi_pkg::*;

   class intersect_board;
      plane_type  plane;
      rsp_type    pending[$];
      int         errors;

      function new();
         plane  = '0;
         errors = 0;
      endfunction

      function automatic longint floor256(longint v);
         return v >>> 8;
      endfunction

      function automatic logic [31:0] clamp(longint p, longint t, longint dl, ref bit sat);
         longint r;
         r = p * 256 + floor256(t * dl);
         if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
            sat = 1;
         end else if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            sat = 1;
         end
         return r[31:0];
      endfunction

      function void note_request(req_type q);
         longint x1, y1, z1, dx, dy, dz, num, den, t, lim;
         rsp_type e;
         bit      sat;
         x1  = q.first_x;
         y1  = q.first_y;
         z1  = q.first_z;
         dx  = longint'(q.second_x) - x1;
         dy  = longint'(q.second_y) - y1;
         dz  = longint'(q.second_z) - z1;
         num = plane.a * x1 + plane.b * y1 + plane.c * z1 + longint'(plane.d);
         den = plane.a * dx + plane.b * dy + plane.c * dz;
         e   = '0;
         sat = 0;
         lim = 64'sd1 <<< 46;
         if (den == 0) begin
            e.parallel = 1;
         end else begin
            t = (-num * 65536) / den;
            if (t > lim) t = lim;
            else if (t < -lim) t = -lim;
            e.hit_x = clamp(x1, t, dx, sat);
            e.hit_y = clamp(y1, t, dy, sat);
            e.hit_z = clamp(z1, t, dz, sat);
            e.saturated = sat;
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type g);
         rsp_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected word", 0, g);
            return;
         end
         e = pending.pop_front();
         if (g.hit_x !== e.hit_x) report_mismatch("hit_x", e.hit_x, g.hit_x);
         if (g.hit_y !== e.hit_y) report_mismatch("hit_y", e.hit_y, g.hit_y);
         if (g.hit_z !== e.hit_z) report_mismatch("hit_z", e.hit_z, g.hit_z);
         if (g.parallel !== e.parallel)
            report_mismatch("parallel", e.parallel, g.parallel);
         if (g.saturated !== e.saturated)
            report_mismatch("saturated", e.saturated, g.saturated);
      endfunction

      function void report_mismatch(string what, logic [127:0] want, logic [127:0] got);
         errors++;
         if (errors <= 40)
            $display("error at %0t: %s want %0h got %0h", $realtime, what, want, got);
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   intersect_board board = new();
   bit  quiet = 0;           // no idling in the last part
   bit  hold_on = 0;
   int  cycles = 0;
   int  expected_total = 0, received = 0;

   line_plane_intersection_top u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("line_plane_intersection_top: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_data);
         received++;
      end
   end

   // receiver stall: random bursts, or a long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_on) begin
            rsp_stall <= 1;
            repeat (120) @(negedge clock);
            rsp_stall <= 0;
            hold_on = 0;
            @(negedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 3);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
            rsp_stall <= 0;
            @(negedge clock);
         end else begin
            @(negedge clock);
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PLANE_A:      board.plane.a = val[15:0];
         CSR_PLANE_B:      board.plane.b = val[15:0];
         CSR_PLANE_C:      board.plane.c = val[15:0];
         CSR_PLANE_OFFSET: board.plane.d = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic set_plane(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [31:0] d);
      write_reg(CSR_PLANE_A, {16'h0, a});
      write_reg(CSR_PLANE_B, {16'h0, b});
      write_reg(CSR_PLANE_C, {16'h0, c});
      write_reg(CSR_PLANE_OFFSET, d);
   endtask

   task automatic drain();
      while (received < expected_total) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic send_word(req_type q);
      int n;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 3);
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      board.note_request(q);
      expected_total++;
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_valid <= 0;
   endtask

   function automatic logic [15:0] pick16(int mode);
      case (mode)
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 16)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type rand_points(bit narrow);
      req_type q;
      if (narrow) begin
         q.first_x  = 16'($urandom_range(0, 4095)) - 16'd2048;
         q.first_y  = 16'($urandom_range(0, 4095)) - 16'd2048;
         q.first_z  = 16'($urandom_range(0, 4095)) - 16'd2048;
         q.second_x = 16'($urandom_range(0, 4095)) - 16'd2048;
         q.second_y = 16'($urandom_range(0, 4095)) - 16'd2048;
         q.second_z = 16'($urandom_range(0, 4095)) - 16'd2048;
      end else begin
         q.first_x  = pick16($urandom_range(0, 9));
         q.first_y  = pick16($urandom_range(0, 9));
         q.first_z  = pick16($urandom_range(0, 9));
         q.second_x = pick16($urandom_range(0, 9));
         q.second_y = pick16($urandom_range(0, 9));
         q.second_z = pick16($urandom_range(0, 9));
      end
      // sometimes a line with no extent in x or in y
      if ($urandom_range(0, 15) == 0) q.second_x = q.first_x;
      if ($urandom_range(0, 31) == 0) q.second_y = q.first_y;
      return q;
   endfunction

   initial begin
      req_type q;
      logic [15:0] pa, pb, pc;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // plane left at reset: every line is parallel
      send_word('{16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600});
      end_burst();
      drain();

      // z = 1 plane, then extremes
      set_plane(16'h0000, 16'h0000, 16'h0100, 32'hffff_0000);
      send_word('{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0200});
      send_word('{16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0300});
      send_word('{16'h0100, 16'h0200, 16'h0100, 16'h0400, 16'h0500, 16'h0100});
      send_word('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
      send_word('{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000});
      send_word('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001});
      send_word('{16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000, 16'h0001});
      send_word('{16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h8000});
      end_burst();
      drain();

      set_plane(16'h8000, 16'h7fff, 16'h8000, 32'h8000_0000);
      send_word('{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff});
      send_word('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
      send_word('{16'h0001, 16'h0001, 16'h0000, 16'h0002, 16'h0002, 16'h0000});
      send_word('{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0001});
      end_burst();
      drain();

      set_plane(16'h7fff, 16'h7fff, 16'h7fff, 32'h7fff_ffff);
      send_word('{16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0000});
      send_word('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8001});
      end_burst();
      drain();
      // unused register index is ignored
      write_reg(3'd5, 32'h1234_5678);
      write_reg(3'd7, 32'hffff_ffff);
      send_word('{16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000});
      end_burst();
      drain();

      // random phases, each with a fresh plane
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 11) quiet = 1;
         case (ph % 4)
            0: begin
               pa = 16'($urandom_range(0, 1023)) - 16'd512;
               pb = 16'($urandom_range(0, 1023)) - 16'd512;
               pc = 16'($urandom_range(0, 1023)) - 16'd512;
            end
            1: begin
               pa = pick16($urandom_range(0, 3));
               pb = pick16($urandom_range(0, 3));
               pc = pick16($urandom_range(0, 3));
            end
            2: begin
               pa = 16'h0100;
               pb = 16'h0000;
               pc = 16'($urandom);
            end
            default: begin
               pa = 16'($urandom);
               pb = 16'($urandom);
               pc = 16'($urandom);
            end
         endcase
         set_plane(pa, pb, pc, $urandom);
         if (ph == 3) hold_on = 1;
         for (int i = 0; i < 150; i++) begin
            q = rand_points($urandom_range(0, 2) != 0);
            send_word(q);
         end
         end_burst();
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("line_plane_intersection_top: match");
      else
         $display("line_plane_intersection_top: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
sv/lpi_pkg.sv
sv/lpi_front.sv
sv/lpi_div_cell.sv
sv/lpi_back.sv
sv/line_plane_intersection_top.sv
tb/sv/tb_line_plane_intersection_top.sv
